// File: hw/rtl/ktqs_pkg.sv
package ktqs_pkg;

    typedef enum logic [4:0] {
        S_LOAD,
        S_POP,
        S_POP_WAIT,
        S_M1_RD,
        S_M1_WAIT,
        S_M1_SW,
        S_M2_RD,
        S_M2_WAIT,
        S_M2_SW,
        S_M3_RD,
        S_M3_WAIT,
        S_M3_SW,
        S_M4_RD,
        S_M4_WAIT,
        S_M4_SW,
        S_PV_RD,
        S_PV_WAIT,
        S_PV_SW,
        S_PT_RD,
        S_PT_WAIT,
        S_PT_SW,
        S_FIN_RD,
        S_FIN_WAIT,
        S_FIN_SW,
        S_PUSH,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    // pair selectors for the two memory read ports
    typedef enum logic [3:0] {
        SEL_LO_MID,
        SEL_LO_HI,
        SEL_MID_HI,
        SEL_MID_HM1,
        SEL_I_STORE,
        SEL_STORE_HI,
        SEL_EMIT
    } t_sel;

    typedef struct packed {
        logic   load;
        logic   clr_set;
        logic   init_sort;
        logic   pop_rd;
        logic   pop_take;
        logic   rd;
        t_sel   sel;
        logic   sw_if_less;
        logic   sw_always;
        logic   sw_if_le_pv;
        logic   take_pv;
        logic   i_init;
        logic   i_step;
        logic   push;
        logic   emit_init;
        logic   emit_rd;
        logic   emit_out;
    } t_cmd;

    typedef struct packed {
        logic   stack_empty;
        logic   range_ok;
        logic   i_done;
        logic   emit_last;
    } t_stat;

endpackage

// File: hw/rtl/key_tag_quicksort_top.sv
// Loads one word per cycle while busy is low; the word with last set starts the sort.
// Sorting runs on one dual-read memory: a partition pass over the compared elements for
// each range taken from the range stack; a single word needs neither a range nor a pass.
// Output: one result at a time, strobed for one cycle, starting once the range stack
// runs empty; busy stays high until the final result; no receiver stall.
// Reset (i_rst_n low, synchronous) empties the set and returns to loading.
module key_tag_quicksort_top
    import ktqs_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic                       i_last,
    output logic                       o_strobe,
    output logic signed [KEY_BITS-1:0] o_sorted_key,
    output logic [TAG_BITS-1:0]        o_sorted_tag,
    output logic                       o_end_of_set,
    output logic                       o_overflow
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_go;

    assign w_go = start;

    ktqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_last  (i_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    ktqs_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_key        (i_key),
        .i_tag        (i_tag),
        .o_stat       (w_stat),
        .o_strobe     (o_strobe),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_end_of_set (o_end_of_set),
        .o_overflow   (o_overflow)
    );

endmodule

// File: hw/rtl/ktqs_ctrl.sv
module ktqs_ctrl
    import ktqs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_go,
    input  logic   i_last,
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output logic   o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:     if (i_go && i_last) n_state = S_POP;
            S_POP:      n_state = i_stat.stack_empty ? S_EMIT_RD : S_POP_WAIT;
            S_POP_WAIT: n_state = i_stat.range_ok ? S_M1_RD : S_POP;
            S_M1_RD:    n_state = S_M1_WAIT;
            S_M1_WAIT:  n_state = S_M1_SW;
            S_M1_SW:    n_state = S_M2_RD;
            S_M2_RD:    n_state = S_M2_WAIT;
            S_M2_WAIT:  n_state = S_M2_SW;
            S_M2_SW:    n_state = S_M3_RD;
            S_M3_RD:    n_state = S_M3_WAIT;
            S_M3_WAIT:  n_state = S_M3_SW;
            S_M3_SW:    n_state = S_M4_RD;
            S_M4_RD:    n_state = S_M4_WAIT;
            S_M4_WAIT:  n_state = S_M4_SW;
            S_M4_SW:    n_state = S_PV_RD;
            S_PV_RD:    n_state = S_PV_WAIT;
            S_PV_WAIT:  n_state = S_PV_SW;
            S_PV_SW:    n_state = S_PT_RD;
            S_PT_RD:    n_state = i_stat.i_done ? S_FIN_RD : S_PT_WAIT;
            S_PT_WAIT:  n_state = S_PT_SW;
            S_PT_SW:    n_state = S_PT_RD;
            S_FIN_RD:   n_state = S_FIN_WAIT;
            S_FIN_WAIT: n_state = S_FIN_SW;
            S_FIN_SW:   n_state = S_PUSH;
            S_PUSH:     n_state = S_POP;
            S_EMIT_RD:  n_state = S_EMIT;
            S_EMIT:     n_state = i_stat.emit_last ? S_LOAD : S_EMIT_RD;
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_busy        = 1'b0;
                o_cmd.load    = i_go;
                o_cmd.init_sort = i_go && i_last;
            end
            S_POP:      o_cmd.pop_rd   = 1'b1;
            S_POP_WAIT: o_cmd.pop_take = 1'b1;
            S_M1_RD:    begin o_cmd.rd = 1'b1; o_cmd.sel = SEL_LO_MID; end
            S_M1_SW:    begin o_cmd.sel = SEL_LO_MID;  o_cmd.sw_if_less = 1'b1; end
            S_M2_RD:    begin o_cmd.rd = 1'b1; o_cmd.sel = SEL_LO_HI; end
            S_M2_SW:    begin o_cmd.sel = SEL_LO_HI;   o_cmd.sw_if_less = 1'b1; end
            S_M3_RD:    begin o_cmd.rd = 1'b1; o_cmd.sel = SEL_MID_HI; end
            S_M3_SW:    begin o_cmd.sel = SEL_MID_HI;  o_cmd.sw_if_less = 1'b1; end
            S_M4_RD:    begin o_cmd.rd = 1'b1; o_cmd.sel = SEL_MID_HM1; end
            S_M4_SW:    begin o_cmd.sel = SEL_MID_HM1; o_cmd.sw_always = 1'b1; end
            S_PV_RD:    begin o_cmd.rd = 1'b1; o_cmd.sel = SEL_MID_HI; end
            S_PV_SW: begin
                o_cmd.sel       = SEL_MID_HI;
                o_cmd.sw_always = 1'b1;
                o_cmd.take_pv   = 1'b1;
                o_cmd.i_init    = 1'b1;
            end
            S_PT_RD:    begin o_cmd.rd = !i_stat.i_done; o_cmd.sel = SEL_I_STORE; end
            S_PT_SW: begin
                o_cmd.sel         = SEL_I_STORE;
                o_cmd.sw_if_le_pv = 1'b1;
                o_cmd.i_step      = 1'b1;
            end
            S_FIN_RD:   begin o_cmd.rd = 1'b1; o_cmd.sel = SEL_STORE_HI; end
            S_FIN_SW:   begin o_cmd.sel = SEL_STORE_HI; o_cmd.sw_always = 1'b1; end
            S_PUSH:     o_cmd.push = 1'b1;
            S_EMIT_RD: begin
                o_cmd.sel     = SEL_EMIT;
                o_cmd.emit_rd = 1'b1;
            end
            S_EMIT: begin
                o_cmd.sel      = SEL_EMIT;
                o_cmd.emit_out = 1'b1;
                o_cmd.clr_set  = i_stat.emit_last;
            end
            default: ;
        endcase
        if (r_state == S_POP && i_stat.stack_empty) o_cmd.emit_init = 1'b1;
    end

endmodule

// File: hw/rtl/ktqs_datapath.sv
module ktqs_datapath
    import ktqs_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0]        i_tag,
    output t_stat                      o_stat,
    output logic                       o_strobe,
    output logic signed [KEY_BITS-1:0] o_sorted_key,
    output logic [TAG_BITS-1:0]        o_sorted_tag,
    output logic                       o_end_of_set,
    output logic                       o_overflow
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = AW + 1;

    logic signed [KEY_BITS-1:0] r_key_mem [MAX_ITEMS];
    logic [TAG_BITS-1:0]        r_tag_mem [MAX_ITEMS];
    logic [2*AW-1:0]            r_stk_mem [MAX_ITEMS];

    logic [CW-1:0] r_count, r_sp;
    logic          r_ovf;
    logic [AW-1:0] r_lo, r_hi, r_i, r_store;
    logic [CW-1:0] r_emit;
    logic [2*AW-1:0] r_pop_q;
    logic signed [KEY_BITS-1:0] r_pv;
    logic signed [KEY_BITS-1:0] r_ka, r_kb;
    logic [TAG_BITS-1:0]        r_ta, r_tb;

    logic [AW-1:0] w_mid, w_a, w_b, w_plo, w_phi;
    logic [AW:0]   w_sum;
    logic          w_do_sw;
    logic [CW-1:0] w_cnt_next;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[AW:1];
    assign w_plo = r_pop_q[2*AW-1:AW];
    assign w_phi = r_pop_q[AW-1:0];
    assign w_cnt_next = (r_count < CW'(MAX_ITEMS)) ? r_count + CW'(1) : r_count;

    always_comb begin
        w_a = r_lo;
        w_b = w_mid;
        case (i_cmd.sel)
            SEL_LO_MID:   begin w_a = r_lo;    w_b = w_mid; end
            SEL_LO_HI:    begin w_a = r_lo;    w_b = r_hi; end
            SEL_MID_HI:   begin w_a = w_mid;   w_b = r_hi; end
            SEL_MID_HM1:  begin w_a = w_mid;   w_b = r_hi - AW'(1); end
            SEL_I_STORE:  begin w_a = r_i;     w_b = r_store; end
            SEL_STORE_HI: begin w_a = r_store; w_b = r_hi; end
            SEL_EMIT:     begin w_a = r_emit[AW-1:0]; w_b = r_emit[AW-1:0]; end
            default:      begin w_a = r_lo;    w_b = w_mid; end
        endcase
    end

    // swap when commanded always, when b < a (median steps) or when a <= pivot (partition)
    always_comb begin
        w_do_sw = i_cmd.sw_always
               || (i_cmd.sw_if_less && (r_kb < r_ka))
               || (i_cmd.sw_if_le_pv && !(r_pv < r_ka));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.emit_rd) begin
            r_ka <= r_key_mem[w_a];
            r_kb <= r_key_mem[w_b];
            r_ta <= r_tag_mem[w_a];
            r_tb <= r_tag_mem[w_b];
        end
        if (i_cmd.load && (r_count < CW'(MAX_ITEMS))) begin
            r_key_mem[r_count[AW-1:0]] <= i_key;
            r_tag_mem[r_count[AW-1:0]] <= i_tag;
        end else if (w_do_sw) begin
            r_key_mem[w_a] <= r_kb;
            r_key_mem[w_b] <= r_ka;
            r_tag_mem[w_a] <= r_tb;
            r_tag_mem[w_b] <= r_ta;
        end
        if (i_cmd.pop_rd) r_pop_q <= r_stk_mem[r_sp[AW-1:0] - AW'(1)];
        if (i_cmd.take_pv) r_pv <= r_ka;
    end

    // push right part first, then left; same order as the recursion unrolled
    logic w_push_r, w_push_l;
    assign w_push_r = ({1'b0, r_store} + CW'(1)) < {1'b0, r_hi};
    assign w_push_l = {1'b0, r_store} > ({1'b0, r_lo} + CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_sort) begin
            if (w_cnt_next > CW'(1))
                r_stk_mem[0] <= {AW'(0), AW'(w_cnt_next - CW'(1))};
        end
        if (i_cmd.push) begin
            if (w_push_r && w_push_l) begin
                r_stk_mem[r_sp[AW-1:0]]          <= {r_store + AW'(1), r_hi};
                r_stk_mem[r_sp[AW-1:0] + AW'(1)] <= {r_lo, r_store - AW'(1)};
            end else if (w_push_r) begin
                r_stk_mem[r_sp[AW-1:0]] <= {r_store + AW'(1), r_hi};
            end else if (w_push_l) begin
                r_stk_mem[r_sp[AW-1:0]] <= {r_lo, r_store - AW'(1)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sp     <= '0;
            r_ovf    <= 1'b0;
            r_emit   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cmd.load) begin
                r_count <= w_cnt_next;
                if (r_count >= CW'(MAX_ITEMS)) r_ovf <= 1'b1;
            end
            if (i_cmd.init_sort) r_sp <= (w_cnt_next > CW'(1)) ? CW'(1) : CW'(0);
            if (i_cmd.pop_rd && r_sp != '0) r_sp <= r_sp - CW'(1);
            if (i_cmd.push)
                r_sp <= r_sp + CW'(w_push_r) + CW'(w_push_l);
            if (i_cmd.emit_init) r_emit <= '0;
            if (i_cmd.emit_out) begin
                o_strobe <= 1'b1;
                r_emit   <= r_emit + CW'(1);
            end
            if (i_cmd.clr_set) begin
                r_count <= '0;
                r_sp    <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_take) begin
            r_lo <= w_plo;
            r_hi <= w_phi;
        end
        if (i_cmd.i_init) begin
            r_i     <= r_lo;
            r_store <= r_lo;
        end
        if (i_cmd.i_step) begin
            r_i <= r_i + AW'(1);
            if (w_do_sw) r_store <= r_store + AW'(1);
        end
        if (i_cmd.emit_out) begin
            o_sorted_key <= r_ka;
            o_sorted_tag <= r_ta;
            o_end_of_set <= (r_emit + CW'(1) == r_count);
            o_overflow   <= r_ovf;
        end
    end

    assign o_stat.stack_empty = (r_sp == '0);
    assign o_stat.range_ok    = w_phi > w_plo;
    assign o_stat.i_done      = (r_i == r_hi);
    assign o_stat.emit_last   = (r_emit + CW'(1) >= r_count);

endmodule

// File: dv/key_tag_quicksort_top_tb.sv
module key_tag_quicksort_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;

    typedef struct {
        logic signed [31:0] key;
        logic [15:0]        tag;
        logic               eos;
        logic               ovf;
    } t_sorted_word;

    class sort_scoreboard;
        logic signed [31:0] keys[CAP];
        logic [15:0]        tags[CAP];
        int                 held;
        bit                 dropped;
        t_sorted_word       pending[$];
        int                 mismatches;
        int                 words_checked;
        int                 sets_done;

        function void swap_pair(int a, int b);
            logic signed [31:0] tk;
            logic [15:0]        tt;
            tk = keys[a]; keys[a] = keys[b]; keys[b] = tk;
            tt = tags[a]; tags[a] = tags[b]; tags[b] = tt;
        endfunction

        // quicksort with the median-of-three pivot quirk, explicit range stack
        function void sort_set();
            int ranges_lo[$];
            int ranges_hi[$];
            int lo, hi, mid, slot;
            logic signed [31:0] pv;
            if (held > 1) begin
                ranges_lo.push_back(0);
                ranges_hi.push_back(held - 1);
            end
            while (ranges_lo.size() > 0) begin
                lo = ranges_lo.pop_back();
                hi = ranges_hi.pop_back();
                if (hi <= lo) continue;
                mid = (lo + hi) / 2;
                if (keys[mid] < keys[lo]) swap_pair(lo, mid);
                if (keys[hi] < keys[lo]) swap_pair(lo, hi);
                if (keys[hi] < keys[mid]) swap_pair(mid, hi);
                swap_pair(mid, hi - 1);
                pv = keys[mid];
                swap_pair(mid, hi);
                slot = lo;
                for (int i = lo; i < hi; i++) begin
                    if (!(pv < keys[i])) begin
                        swap_pair(i, slot);
                        slot++;
                    end
                end
                swap_pair(slot, hi);
                if (slot + 1 < hi) begin
                    ranges_lo.push_back(slot + 1);
                    ranges_hi.push_back(hi);
                end
                if (slot > lo + 1) begin
                    ranges_lo.push_back(lo);
                    ranges_hi.push_back(slot - 1);
                end
            end
        endfunction

        function void note_word(logic signed [31:0] key, logic [15:0] tag, logic last);
            t_sorted_word w;
            if (held < CAP) begin
                keys[held] = key;
                tags[held] = tag;
                held++;
            end else begin
                dropped = 1;
            end
            if (last) begin
                sort_set();
                for (int k = 0; k < held; k++) begin
                    w.key = keys[k];
                    w.tag = tags[k];
                    w.eos = (k == held - 1);
                    w.ovf = dropped;
                    pending.push_back(w);
                end
                held = 0;
                dropped = 0;
            end
        endfunction

        function void check_word(logic signed [31:0] key, logic [15:0] tag,
                                 logic eos, logic ovf);
            t_sorted_word w;
            words_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: key %0d tag %0h eos %b ovf %b",
                             key, tag, eos, ovf);
                return;
            end
            w = pending.pop_front();
            if (eos) sets_done++;
            if (w.key !== key || w.tag !== tag || w.eos !== eos || w.ovf !== ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp key %0d tag %0h eos %b ovf %b, ",
                              "got key %0d tag %0h eos %b ovf %b"},
                             w.key, w.tag, w.eos, w.ovf, key, tag, eos, ovf);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_key;
    logic [15:0]        i_tag;
    logic               i_last;
    logic               o_strobe;
    logic signed [31:0] o_sorted_key;
    logic [15:0]        o_sorted_tag;
    logic               o_end_of_set;
    logic               o_overflow;

    sort_scoreboard sb;
    int             idle_pct;
    int             words_sent;

    key_tag_quicksort_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_key(i_key), .i_tag(i_tag), .i_last(i_last),
        .o_strobe(o_strobe), .o_sorted_key(o_sorted_key),
        .o_sorted_tag(o_sorted_tag), .o_end_of_set(o_end_of_set),
        .o_overflow(o_overflow)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_word(o_sorted_key, o_sorted_tag, o_end_of_set, o_overflow);
    end

    // present one word, hold until taken; start stays high between back-to-back words
    task automatic send_word(logic signed [31:0] key, logic [15:0] tag, logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start  <= 1;
        i_key  <= key;
        i_tag  <= tag;
        i_last <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word(key, tag, last);
        words_sent++;
    endtask

    function automatic logic signed [31:0] pick_key(int style);
        case (style)
            0: return $urandom_range(7) - 4;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(int n, int style);
        for (int k = 0; k < n; k++)
            send_word(pick_key(style), 16'($urandom), k == n - 1);
    endtask

    task automatic send_list(logic signed [31:0] ks[$]);
        for (int k = 0; k < ks.size(); k++)
            send_word(ks[k], 16'(k), k == ks.size() - 1);
    endtask

    initial begin
        int n;
        sb = new();
        i_rst_n  = 0;
        start    = 0;
        i_key    = 0;
        i_tag    = 0;
        i_last   = 0;
        idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // single word, extremes, ties, sorted and reversed order, and one mixed list
        send_word(32'sh12345678, 16'hffff, 1);
        send_list('{32'sh7fffffff, 32'sh80000000});
        send_list('{3, 3, 3, 3, 3});
        send_list('{-1, 0, 1, 2, 3});
        send_list('{5, 4, 3, 2, 1, 0, -1, 32'sh80000000});
        send_list('{0, 16'hffff, -2});
        // overflow: two dropped words, the last one among them
        for (int k = 0; k < CAP + 2; k++)
            send_word($urandom, 16'($urandom), k == CAP + 1);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 65 : (phase == 3) ? 15 : 0;
            while (words_sent < 25 + CAP + (phase + 1) * 90) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(CAP + 3, 40)
                                             : $urandom_range(12, 1);
                send_set(n, $urandom_range(2));
            end
        end
        start <= 0;

        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d words in %0d sets, checked %0d sorted words",
                 words_sent, sb.sets_done, sb.words_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/ktqs_pkg.sv
hw/rtl/ktqs_ctrl.sv
hw/rtl/ktqs_datapath.sv
hw/rtl/key_tag_quicksort_top.sv
dv/key_tag_quicksort_top_tb.sv
